/* src/rled_pkg.sv */
// ----------------------------------------------------------------------------
// rled_pkg
// Shared types and codes for the range list entry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rled_pkg;

  // width of a fixed-size address in the list, in bytes (4 to 8)
  localparam int ADDR_BYTES  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // entry codes of the list
  localparam logic [7:0] CODE_END         = 8'h00;
  localparam logic [7:0] CODE_OFFSET_PAIR = 8'h04;
  localparam logic [7:0] CODE_BASE_ADDR   = 8'h05;
  localparam logic [7:0] CODE_START_LEN   = 8'h07;

  // result kinds
  localparam logic [1:0] KIND_RANGE  = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_UNSUP  = 2'd2;
  localparam logic [1:0] KIND_NOBASE = 2'd3;

  // configuration register indexes
  localparam logic CFG_UNIT_BASE_ADDR    = 1'b0;
  localparam logic CFG_UNIT_BASE_PRESENT = 1'b1;

  typedef logic [3:0] op_code_t;

  // operations passed from the front to the back
  localparam op_code_t OP_CODE       = 4'd0;   // new entry: clear accumulator
  localparam op_code_t OP_ADDR       = 4'd1;   // address byte
  localparam op_code_t OP_ADDR_BASE  = 4'd2;   // last address byte, load list base
  localparam op_code_t OP_ADDR_START = 4'd3;   // last address byte, load start
  localparam op_code_t OP_LEB        = 4'd4;   // LEB128 continuation byte
  localparam op_code_t OP_OFS1_DONE  = 4'd5;   // last byte of first offset
  localparam op_code_t OP_OFS2_DONE  = 4'd6;   // last byte of second offset, emit
  localparam op_code_t OP_LEN_DONE   = 4'd7;   // last byte of length, emit
  localparam op_code_t OP_END        = 4'd8;
  localparam op_code_t OP_UNSUP      = 4'd9;
  localparam op_code_t OP_NOBASE     = 4'd10;

  typedef struct packed {
    op_code_t   op;
    logic [7:0] data;
    logic [3:0] idx;            // byte position within the field
    logic       use_list_base;  // offset pair adds the list base
  } op_t;

endpackage

`default_nettype wire

/* src/rled_front.sv */
// ----------------------------------------------------------------------------
// rled_front
// Parses entry structure byte by byte and issues one operation per accepted byte until the list halts.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire [7:0]           data_byte,
  input  wire                 first,
  input  wire                 q_full,
  input  wire                 unit_base_present,
  output logic                in_ready,
  output logic                push,
  output rled_pkg::op_t       push_op
);

  localparam logic [2:0] PH_CODE = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_OFS1 = 3'd2;
  localparam logic [2:0] PH_OFS2 = 3'd3;
  localparam logic [2:0] PH_LEN  = 3'd4;

  logic [2:0] phase, phase_next;
  logic [3:0] byte_count, byte_count_next;
  logic       is_base, is_base_next;
  logic       halted, halted_next;
  logic       lb_valid, lb_valid_next;

  logic       accept;
  logic [2:0] ph;
  logic [3:0] cnt;
  logic [3:0] cnt_inc;
  logic [3:0] cnt_sat;
  logic       hlt;
  logic       lbv;
  logic       leb_done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // a byte flagged first restarts the list
    ph       = first ? PH_CODE : phase;
    cnt      = first ? 4'd0 : byte_count;
    hlt      = first ? 1'b0 : halted;
    lbv      = first ? 1'b0 : lb_valid;
    cnt_inc  = cnt + 4'd1;
    cnt_sat  = (cnt == 4'd15) ? cnt : cnt_inc;
    leb_done = !data_byte[7];

    phase_next      = ph;
    byte_count_next = cnt;
    is_base_next    = is_base;
    halted_next     = hlt;
    lb_valid_next   = lbv;

    push                  = 1'b0;
    push_op.op            = rled_pkg::OP_CODE;
    push_op.data          = data_byte;
    push_op.idx           = cnt;
    push_op.use_list_base = lbv;

    if (!hlt) begin
      push = 1'b1;
      unique case (ph)
        PH_CODE: begin
          byte_count_next = 4'd0;
          if (data_byte == rled_pkg::CODE_END) begin
            push_op.op  = rled_pkg::OP_END;
            halted_next = 1'b1;
          end else if (data_byte == rled_pkg::CODE_OFFSET_PAIR) begin
            if (!lbv && !unit_base_present) begin
              push_op.op  = rled_pkg::OP_NOBASE;
              halted_next = 1'b1;
            end else begin
              phase_next = PH_OFS1;
            end
          end else if (data_byte == rled_pkg::CODE_BASE_ADDR ||
                       data_byte == rled_pkg::CODE_START_LEN) begin
            phase_next   = PH_ADDR;
            is_base_next = (data_byte == rled_pkg::CODE_BASE_ADDR);
          end else begin
            push_op.op  = rled_pkg::OP_UNSUP;
            halted_next = 1'b1;
          end
        end
        PH_ADDR: begin
          if (cnt_inc >= 4'(rled_pkg::ADDR_BYTES)) begin
            byte_count_next = 4'd0;
            if (is_base) begin
              push_op.op    = rled_pkg::OP_ADDR_BASE;
              lb_valid_next = 1'b1;
              phase_next    = PH_CODE;
            end else begin
              push_op.op = rled_pkg::OP_ADDR_START;
              phase_next = PH_LEN;
            end
          end else begin
            push_op.op      = rled_pkg::OP_ADDR;
            byte_count_next = cnt_inc;
          end
        end
        PH_OFS1, PH_OFS2, PH_LEN: begin
          if (leb_done) begin
            byte_count_next = 4'd0;
            if (ph == PH_OFS1) begin
              push_op.op = rled_pkg::OP_OFS1_DONE;
              phase_next = PH_OFS2;
            end else if (ph == PH_OFS2) begin
              push_op.op = rled_pkg::OP_OFS2_DONE;
              phase_next = PH_CODE;
            end else begin
              push_op.op = rled_pkg::OP_LEN_DONE;
              phase_next = PH_CODE;
            end
          end else begin
            push_op.op      = rled_pkg::OP_LEB;
            byte_count_next = cnt_sat;
          end
        end
        default: begin
          push            = 1'b0;
          phase_next      = PH_CODE;
          byte_count_next = 4'd0;
        end
      endcase
    end
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CODE;
      byte_count <= 4'd0;
      is_base    <= 1'b0;
      halted     <= 1'b0;
      lb_valid   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      is_base    <= is_base_next;
      halted     <= halted_next;
      lb_valid   <= lb_valid_next;
    end
  end

endmodule

`default_nettype wire

/* src/rled_queue.sv */
// ----------------------------------------------------------------------------
// rled_queue
// Small FIFO of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  rled_pkg::op_t       push_op,
  input  wire                 pop,
  output logic                full,
  output logic                head_valid,
  output rled_pkg::op_t       head_op
);

  rled_pkg::op_t                   mem [rled_pkg::QUEUE_DEPTH];
  logic [rled_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rled_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rled_pkg::QCNT_W-1:0]     count;
  logic                            do_pop;

  assign full       = (count == rled_pkg::QCNT_W'(rled_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rled_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rled_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + rled_pkg::QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - rled_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/rled_back.sv */
// ----------------------------------------------------------------------------
// rled_back
// Assembles address and LEB128 values, forms ranges and end/error reports, holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 head_valid,
  input  rled_pkg::op_t       head_op,
  input  wire [63:0]          unit_base_address,
  input  wire                 out_ready,
  output logic                pop,
  output logic                out_valid,
  output logic [1:0]          kind,
  output logic [63:0]         range_start,
  output logic [63:0]         range_end
);

  logic [63:0] accumulator, accumulator_next;
  logic [63:0] first_value, first_value_next;
  logic [63:0] list_base, list_base_next;

  logic        emits;
  logic        out_free;
  logic [6:0]  leb_amt;
  logic [63:0] addr_part;
  logic [63:0] leb_part;
  logic [63:0] acc_upd;
  logic [63:0] base;
  logic [1:0]  kind_next;
  logic [63:0] start_next;
  logic [63:0] end_next;

  assign out_free = !out_valid || out_ready;
  assign emits    = (head_op.op == rled_pkg::OP_OFS2_DONE) ||
                    (head_op.op == rled_pkg::OP_LEN_DONE)  ||
                    (head_op.op == rled_pkg::OP_END)       ||
                    (head_op.op == rled_pkg::OP_UNSUP)     ||
                    (head_op.op == rled_pkg::OP_NOBASE);
  assign pop      = head_valid && (!emits || out_free);

  always_comb begin
    // 7 * idx: bit offset of a LEB128 group
    leb_amt   = {head_op.idx, 3'b000} - {3'b000, head_op.idx};
    addr_part = {56'd0, head_op.data} << {head_op.idx[2:0], 3'b000};
    leb_part  = (head_op.idx < 4'd10) ?
                ({57'd0, head_op.data[6:0]} << leb_amt[5:0]) : 64'd0;
    base      = head_op.use_list_base ? list_base : unit_base_address;

    unique case (head_op.op)
      rled_pkg::OP_ADDR, rled_pkg::OP_ADDR_BASE, rled_pkg::OP_ADDR_START:
        acc_upd = accumulator | addr_part;
      default:
        acc_upd = accumulator | leb_part;
    endcase

    accumulator_next = 64'd0;
    first_value_next = first_value;
    list_base_next   = list_base;
    kind_next        = rled_pkg::KIND_RANGE;
    start_next       = 64'd0;
    end_next         = 64'd0;

    unique case (head_op.op)
      rled_pkg::OP_ADDR, rled_pkg::OP_LEB: begin
        accumulator_next = acc_upd;
      end
      rled_pkg::OP_ADDR_BASE: begin
        list_base_next = acc_upd;
      end
      rled_pkg::OP_ADDR_START, rled_pkg::OP_OFS1_DONE: begin
        first_value_next = acc_upd;
      end
      rled_pkg::OP_OFS2_DONE: begin
        start_next = first_value + base;
        end_next   = acc_upd + base;
      end
      rled_pkg::OP_LEN_DONE: begin
        start_next = first_value;
        end_next   = first_value + acc_upd;
      end
      rled_pkg::OP_END:    kind_next = rled_pkg::KIND_END;
      rled_pkg::OP_UNSUP:  kind_next = rled_pkg::KIND_UNSUP;
      rled_pkg::OP_NOBASE: kind_next = rled_pkg::KIND_NOBASE;
      default: begin
        // new entry code: accumulator starts from zero
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      accumulator <= accumulator_next;
      first_value <= first_value_next;
      list_base   <= list_base_next;
    end
    if (pop && emits) begin
      kind        <= kind_next;
      range_start <= start_next;
      range_end   <= end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/range_list_entry_decoder_top.sv */
// ----------------------------------------------------------------------------
// range_list_entry_decoder_top
// DWARF 5 range list decoder, one list byte per word.
// ----------------------------------------------------------------------------
// Takes one list byte per clock when the operation queue has room and gives
// at most one result word per byte. The front parser keeps entry phase, byte
// position, halt and list-base-seen flags and turns each byte into an
// operation; a 4-deep queue carries operations to the back end, which
// assembles addresses and LEB128 values and does the 64-bit sums into an
// output register. Sustained rate is one byte per cycle while results are
// taken; through an empty queue the closing byte of an entry passes the queue
// and then the output register before its result word is presented. Bytes after an end, unsupported or
// missing-base report are swallowed until a byte with tuser (first) set.
// Configuration writes are taken at once (cfg_ready is always high) and
// must only be issued while the block is idle.
`default_nettype none

module range_list_entry_decoder_top (
  input  wire          clk,
  input  wire          rst,
  // configuration
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire          cfg_index,
  input  wire  [63:0]  cfg_data,
  // list bytes
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,    // [7:0] data_byte
  input  wire          s_tuser,    // [0] first
  // results
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [127:0] m_tdata,    // [63:0] range_start, [127:64] range_end
  output logic [1:0]   m_tuser     // [1:0] kind
);

  logic [63:0]   unit_base_address;
  logic          unit_base_present;

  logic          q_full;
  logic          push;
  rled_pkg::op_t push_op;
  logic          head_valid;
  rled_pkg::op_t head_op;
  logic          pop;
  logic [63:0]   range_start;
  logic [63:0]   range_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_base_address <= 64'd0;
      unit_base_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rled_pkg::CFG_UNIT_BASE_ADDR:    unit_base_address <= cfg_data;
        rled_pkg::CFG_UNIT_BASE_PRESENT: unit_base_present <= cfg_data[0];
        default:                         unit_base_present <= unit_base_present;
      endcase
    end
  end

  rled_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .data_byte         (s_tdata),
    .first             (s_tuser),
    .q_full            (q_full),
    .unit_base_present (unit_base_present),
    .in_ready          (s_tready),
    .push              (push),
    .push_op           (push_op)
  );

  rled_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  rled_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (head_valid),
    .head_op           (head_op),
    .unit_base_address (unit_base_address),
    .out_ready         (m_tready),
    .pop               (pop),
    .out_valid         (m_tvalid),
    .kind              (m_tuser),
    .range_start       (range_start),
    .range_end         (range_end)
  );

  assign m_tdata = {range_end, range_start};

endmodule

`default_nettype wire

/* dv/tb_range_list_entry_decoder_top.sv */
// ----------------------------------------------------------------------------
// tb_range_list_entry_decoder_top
// Self-checking bench for the range list entry decoder.
// ----------------------------------------------------------------------------
// Feeds range lists one byte per word. It starts with a directed set: end
// marker, missing base, unsupported code, a list cut off mid-entry, address
// wrap and an over-long LEB128. Random lists follow under several unit base
// settings. A local parser predicts every report. Results are compared field
// by field in arrival order. Both sides pace at random. One phase stalls the
// result side long enough to back the block up.

module tb_range_list_entry_decoder_top;

  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  typedef enum int {PACE_NONE, PACE_FULL, PACE_MIXED} pace_t;
  typedef enum logic [2:0] {AT_CODE, AT_ADDR, AT_OFS1, AT_OFS2, AT_LEN} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } feed_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] lo;
    logic [63:0] hi;
  } report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;

  range_list_entry_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  feed_t   byte_feed[$];
  report_t due_reports[$];
  int      n_pushed = 0;
  int      n_taken = 0;
  int      n_live = 0;
  int      n_errors = 0;
  int      n_kind[4] = '{0, 0, 0, 0};
  int      n_settings = 0;
  int      src_wait = 0;
  int      snk_wait = 0;
  int      hold_left = 0;
  int      hold_reqs = 0;
  int      hold_served = 0;
  pace_t   src_pace = PACE_NONE;
  pace_t   snk_pace = PACE_NONE;
  logic    list_open = 1'b0;

  // shadow of the unit base registers
  logic [63:0] unit_addr = '0;
  logic        unit_present = 1'b0;

  // parser state
  parse_phase_t p_phase = AT_CODE;
  logic [7:0]   p_code = '0;
  logic [3:0]   p_cnt = '0;
  logic [63:0]  p_acc = '0;
  logic [63:0]  p_first = '0;
  logic [63:0]  p_base = '0;
  logic         p_base_ok = 1'b0;
  logic         p_halt = 1'b0;

  task automatic log_mismatch(string what);
    n_errors++;
    if (n_errors <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic int draw_wait(pace_t pace);
    case (pace)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, 18);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  function automatic void restart_entry();
    p_phase = AT_CODE;
    p_code  = '0;
    p_cnt   = '0;
    p_acc   = '0;
    p_first = '0;
  endfunction

  function automatic void expect_report(logic [1:0] kind, logic [63:0] lo, logic [63:0] hi);
    report_t r;
    r.kind = kind;
    r.lo   = lo;
    r.hi   = hi;
    due_reports.push_back(r);
  endfunction

  // one LEB128 byte; high when the value is complete
  function automatic logic leb_take(logic [7:0] b);
    if (p_cnt < 10) p_acc |= 64'(b[6:0]) << (7 * p_cnt);
    if (p_cnt < 15) p_cnt++;
    return !b[7];
  endfunction

  function automatic void decode_list_byte(logic [7:0] b, logic first);
    logic [63:0] base;
    if (first) begin
      restart_entry();
      p_base    = '0;
      p_base_ok = 1'b0;
      p_halt    = 1'b0;
    end
    if (p_halt) return;
    case (p_phase)
      AT_CODE: begin
        p_code = b;
        p_cnt  = '0;
        p_acc  = '0;
        if (b == rled_pkg::CODE_END) begin
          p_halt = 1'b1;
          expect_report(rled_pkg::KIND_END, '0, '0);
        end else if (b == rled_pkg::CODE_OFFSET_PAIR) begin
          if (!p_base_ok && !unit_present) begin
            p_halt = 1'b1;
            expect_report(rled_pkg::KIND_NOBASE, '0, '0);
          end else begin
            p_phase = AT_OFS1;
          end
        end else if (b == rled_pkg::CODE_BASE_ADDR || b == rled_pkg::CODE_START_LEN) begin
          p_phase = AT_ADDR;
        end else begin
          p_halt = 1'b1;
          expect_report(rled_pkg::KIND_UNSUP, '0, '0);
        end
      end
      AT_ADDR: begin
        if (p_cnt < 8) p_acc |= 64'(b) << (8 * p_cnt);
        p_cnt++;
        if (p_cnt >= rled_pkg::ADDR_BYTES || p_cnt >= 8) begin
          if (p_code == rled_pkg::CODE_BASE_ADDR) begin
            p_base    = p_acc;
            p_base_ok = 1'b1;
            restart_entry();
          end else begin
            p_first = p_acc;
            p_acc   = '0;
            p_cnt   = '0;
            p_phase = AT_LEN;
          end
        end
      end
      AT_OFS1: begin
        if (leb_take(b)) begin
          p_first = p_acc;
          p_acc   = '0;
          p_cnt   = '0;
          p_phase = AT_OFS2;
        end
      end
      AT_OFS2: begin
        if (leb_take(b)) begin
          // base is sampled when the second offset closes
          base = p_base_ok ? p_base : unit_addr;
          expect_report(rled_pkg::KIND_RANGE, p_first + base, p_acc + base);
          restart_entry();
        end
      end
      AT_LEN: begin
        if (leb_take(b)) begin
          expect_report(rled_pkg::KIND_RANGE, p_first, p_first + p_acc);
          restart_entry();
        end
      end
      default: restart_entry();
    endcase
  endfunction

  // source side
  always @(posedge clk) begin : list_driver
    int    wait_n;
    feed_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      wait_n = src_wait;
      if (s_tvalid && s_tready) begin
        decode_list_byte(s_tdata, s_tuser);
        n_taken++;
        wait_n = draw_wait(src_pace);
      end
      if (s_tvalid && !s_tready) begin
        // word stays up until taken
      end else if (wait_n > 0) begin
        src_wait <= wait_n - 1;
        s_tvalid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
        w = byte_feed.pop_front();
        s_tdata  <= w.data;
        s_tuser  <= w.first;
        s_tvalid <= 1'b1;
        src_wait <= 0;
      end else begin
        s_tvalid <= 1'b0;
        src_wait <= 0;
      end
    end
  end

  // result side
  always @(posedge clk) begin : report_monitor
    report_t want;
    int      wait_n;
    if (rst) begin
      m_tready    <= 1'b0;
      snk_wait    <= 0;
      hold_left   <= 0;
      hold_served <= 0;
    end else begin
      wait_n = snk_wait;
      if (m_tvalid && m_tready) begin
        n_kind[m_tuser]++;
        if (due_reports.size() == 0) begin
          log_mismatch($sformatf("unexpected word kind %0d start %h end %h",
                                 m_tuser, m_tdata[63:0], m_tdata[127:64]));
        end else begin
          want = due_reports.pop_front();
          if (m_tuser !== want.kind)
            log_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
          if (m_tdata[63:0] !== want.lo)
            log_mismatch($sformatf("range_start %h, want %h", m_tdata[63:0], want.lo));
          if (m_tdata[127:64] !== want.hi)
            log_mismatch($sformatf("range_end %h, want %h", m_tdata[127:64], want.hi));
        end
        wait_n = draw_wait(snk_pace);
      end
      if (hold_reqs != hold_served) begin
        hold_served <= hold_reqs;
        hold_left   <= HOLD_CYCLES;
        snk_wait    <= wait_n;
        m_tready    <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        snk_wait  <= wait_n;
        m_tready  <= 1'b0;
      end else if (wait_n > 0) begin
        snk_wait <= wait_n - 1;
        m_tready <= 1'b0;
      end else begin
        snk_wait <= 0;
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rled_pkg::CFG_UNIT_BASE_ADDR) unit_addr = val;
    else unit_present = val[0];
  endtask

  task automatic set_unit_base(logic [63:0] addr, logic present);
    write_reg(rled_pkg::CFG_UNIT_BASE_ADDR, addr);
    write_reg(rled_pkg::CFG_UNIT_BASE_PRESENT, {63'd0, present});
    n_settings++;
  endtask

  // wait for every byte and report, then let the pipeline empty
  task automatic settle();
    while (n_taken != n_pushed || due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_byte(logic [7:0] b);
    feed_t w;
    w.data  = b;
    w.first = list_open;
    list_open = 1'b0;
    byte_feed.push_back(w);
    n_pushed++;
    n_live++;
  endtask

  task automatic put_first(logic [7:0] b);
    list_open = 1'b1;
    put_byte(b);
  endtask

  // trailing bytes the block should swallow
  task automatic put_junk(int count);
    feed_t w;
    repeat (count) begin
      w.data  = 8'($urandom);
      w.first = 1'b0;
      byte_feed.push_back(w);
      n_pushed++;
    end
  endtask

  task automatic put_addr(logic [63:0] a);
    for (int i = 0; i < rled_pkg::ADDR_BYTES; i++) put_byte(a[8*i +: 8]);
  endtask

  // minimal encoding, optionally padded with redundant zero groups
  task automatic put_leb(logic [63:0] v, int pad);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0 || pad > 0) b[7] = 1'b1;
      put_byte(b);
    end while (v != 0);
    while (pad > 0) begin
      pad--;
      put_byte((pad != 0) ? 8'h80 : 8'h00);
    end
  endtask

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic put_rand_leb();
    int n;
    case ($urandom_range(0, 7))
      0: put_leb(64'($urandom_range(0, 127)), 0);
      1: put_leb('1, 0);
      2: put_leb(rand_addr(), $urandom_range(1, 3));
      3: begin
        // long value: groups past bit 63 and a saturating count
        n = $urandom_range(11, 20);
        repeat (n - 1) put_byte(8'h80 | 8'($urandom));
        put_byte(8'($urandom_range(0, 127)));
      end
      default: put_leb({$urandom, $urandom} >> $urandom_range(0, 60), 0);
    endcase
  endtask

  task automatic gen_list();
    int         pick;
    logic [7:0] code;
    list_open = 1'b1;
    if ($urandom_range(0, 99) < (unit_present ? 40 : 85)) begin
      put_byte(rled_pkg::CODE_BASE_ADDR);
      put_addr(rand_addr());
    end
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        put_byte(rled_pkg::CODE_OFFSET_PAIR);
        put_rand_leb();
        put_rand_leb();
      end else if (pick < 14) begin
        put_byte(rled_pkg::CODE_START_LEN);
        put_addr(rand_addr());
        put_rand_leb();
      end else if (pick < 16) begin
        put_byte(rled_pkg::CODE_BASE_ADDR);
        put_addr(rand_addr());
      end else if (pick < 18) begin
        // list breaks off mid-entry; next list restarts the parser
        put_byte((pick == 16) ? rled_pkg::CODE_START_LEN : rled_pkg::CODE_OFFSET_PAIR);
        repeat ($urandom_range(0, 4)) put_byte(8'h80 | 8'($urandom));
        return;
      end else begin
        do code = 8'($urandom);
        while (code == rled_pkg::CODE_END || code == rled_pkg::CODE_OFFSET_PAIR ||
               code == rled_pkg::CODE_BASE_ADDR || code == rled_pkg::CODE_START_LEN);
        put_byte(code);
        put_junk($urandom_range(0, 4));
        return;
      end
    end
    put_byte(rled_pkg::CODE_END);
    put_junk($urandom_range(0, 3));
  endtask

  initial begin
    int live_mark;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: no unit base, with end, cut-off, unsupported and list-base lists
    set_unit_base('0, 1'b0);
    put_first(rled_pkg::CODE_OFFSET_PAIR);
    put_junk(1);
    put_first(rled_pkg::CODE_END);
    put_first(rled_pkg::CODE_START_LEN);
    for (int i = 1; i < 8; i++) put_byte(8'(i * 8'h11));
    put_first(8'hFF);
    put_first(rled_pkg::CODE_BASE_ADDR);
    put_addr('1);
    put_byte(rled_pkg::CODE_OFFSET_PAIR);
    put_byte(8'h7F);
    put_byte(8'h01);
    put_byte(rled_pkg::CODE_END);
    settle();

    // directed: unit base at the top, offset with bits past 63
    set_unit_base('1, 1'b1);
    put_first(rled_pkg::CODE_OFFSET_PAIR);
    put_byte(8'h02);
    repeat (9) put_byte(8'h80);
    put_byte(8'h03);
    put_byte(rled_pkg::CODE_END);
    settle();

    for (int stage = 0; stage < 5; stage++) begin
      case (stage)
        0: begin
          set_unit_base({$urandom, $urandom}, 1'b1);
          src_pace = PACE_MIXED;
          snk_pace = PACE_MIXED;
        end
        1: begin
          set_unit_base('0, 1'b0);
          src_pace = PACE_FULL;
          snk_pace = PACE_NONE;
        end
        2: begin
          set_unit_base('1, 1'b1);
          src_pace = PACE_NONE;
          snk_pace = PACE_NONE;
          hold_reqs++;
        end
        3: begin
          set_unit_base({$urandom, $urandom}, 1'b0);
          src_pace = PACE_NONE;
          snk_pace = PACE_FULL;
        end
        default: begin
          set_unit_base({$urandom, $urandom}, 1'b1);
          src_pace = PACE_FULL;
          snk_pace = PACE_FULL;
        end
      endcase
      live_mark = n_live;
      while (n_live < live_mark + 48) gen_list();
      settle();
    end

    $display("Covered %0d list bytes under %0d unit base settings, one %0d-cycle output stall",
             n_taken, n_settings, HOLD_CYCLES);
    $display("Reports: %0d ranges, %0d ends, %0d unsupported, %0d missing base",
             n_kind[rled_pkg::KIND_RANGE], n_kind[rled_pkg::KIND_END],
             n_kind[rled_pkg::KIND_UNSUP], n_kind[rled_pkg::KIND_NOBASE]);
    if (n_errors == 0) begin
      $display("PASS range_list_entry_decoder_top");
    end else begin
      $display("FAIL range_list_entry_decoder_top");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout: %0d bytes taken of %0d, %0d reports outstanding",
             n_taken, n_pushed, due_reports.size());
    $display("FAIL range_list_entry_decoder_top");
    $finish;
  end

endmodule
